// ===== design/convex_hull_monotone_chain_defines.svh =====
// Assertion macros shared by the checking code.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_DEFINES_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_DEFINES_SVH

// same-cycle implication
`define CHMC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define CHMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/chmc_pkg.sv =====
package chmc_pkg;
    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 16;
    localparam int SMALL_SET   = 3;
    localparam int STACK_DEPTH = 2 * MAX_POINTS;
    localparam int PTR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = PTR_W + 1;
    localparam int STK_W       = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = STK_W + 1;
    localparam int DATA_W      = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    typedef struct packed {
        point_t o;
        point_t a;
        point_t b;
    } turn_t;

    function automatic logic pt_less(input point_t a, input point_t b);
        return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
    endfunction
endpackage

// ===== design/chmc_cross.sv =====
module chmc_cross (
    input  logic            aclk,
    input  chmc_pkg::turn_t turn,
    output logic            pop
);
    import chmc_pkg::*;

    logic signed [DIFF_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;
    logic signed [PROD_W:0]   diff;
    logic                     pop_reg;

    assign diff = {p1_reg[PROD_W-1], p1_reg} - {p2_reg[PROD_W-1], p2_reg};

    always_ff @(posedge aclk) begin
        ax_reg  <= DIFF_W'(turn.a.x) - DIFF_W'(turn.o.x);
        ay_reg  <= DIFF_W'(turn.a.y) - DIFF_W'(turn.o.y);
        bx_reg  <= DIFF_W'(turn.b.x) - DIFF_W'(turn.o.x);
        by_reg  <= DIFF_W'(turn.b.y) - DIFF_W'(turn.o.y);
        p1_reg  <= PROD_W'(ax_reg) * PROD_W'(by_reg);
        p2_reg  <= PROD_W'(ay_reg) * PROD_W'(bx_reg);
        pop_reg <= diff[PROD_W] || (diff == '0);
    end

    assign pop = pop_reg;
endmodule

// ===== design/convex_hull_monotone_chain.sv =====
// Convex hull of a 2-D point set (monotone chain), one point per transfer.
// Input: s_tdata = {y, x} (x in low bits), s_tlast marks the final point.
// Each point is stored and insertion-sorted on arrival; s_tready stays low
// meanwhile. The final point starts the hull passes on one shared 3-stage
// cross-product unit. Sets of three or fewer points are echoed.
// Output: m_tdata = {y, x}, m_tlast on the last vertex, m_tuser = overflow.
// A stalled vertex holds in the output register. No new point is accepted
// until the last vertex transfers.
// More than 64 points: extra points are dropped and overflow is flagged.
// Reset (aresetn low, synchronous) clears the count and control state; no
// clearing pass is needed.
module convex_hull_monotone_chain (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [chmc_pkg::DATA_W-1:0] s_tdata,   // point_x, point_y
    input  logic                        s_tlast,   // last_point
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [chmc_pkg::DATA_W-1:0] m_tdata,   // hull_x, hull_y
    output logic                        m_tlast,   // last_vertex
    output logic                        m_tuser    // overflow
);
    import chmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_HULL_RD, S_HULL_GET, S_CHK_RD, S_CHK_FEED,
        S_CHK_W1, S_CHK_W2, S_CHK_DEC, S_PUSH, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 ovf_reg;
    logic                 last_reg;
    point_t               vin_reg;
    logic [PTR_W-1:0]     j_reg;
    logic [PTR_W-1:0]     idx_reg;
    logic                 upper_reg;
    logic [STK_CNT_W-1:0] k_reg;
    logic [STK_CNT_W-1:0] t_reg;
    logic [CNT_W-1:0]     m_reg;
    logic [CNT_W-1:0]     e_reg;
    logic                 echo_reg;
    point_t               p_reg;
    point_t               out_pt_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic                 out_ovf_reg;

    point_t store_mem [MAX_POINTS];
    point_t sort_mem  [MAX_POINTS];
    point_t stk_mem   [STACK_DEPTH];
    point_t store_rd_reg, sort_rd_reg, stk_rd0_reg, stk_rd1_reg;

    point_t               in_pt;
    logic                 s_fire;
    logic                 sort_we;
    logic [PTR_W-1:0]     sort_waddr;
    point_t               sort_wdata;
    logic [PTR_W-1:0]     sort_raddr;
    logic                 stk_we;
    logic [STK_W-1:0]     stk_raddr0, stk_raddr1;
    logic [STK_CNT_W-1:0] limit;
    logic [STK_CNT_W-1:0] k_dec, m_full;
    turn_t                turn;
    logic                 pop;

    assign in_pt.x = s_tdata[COORD_BITS-1:0];
    assign in_pt.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign limit = upper_reg ? t_reg : STK_CNT_W'(2);
    assign k_dec = k_reg - STK_CNT_W'(1);
    assign m_full = (k_dec > STK_CNT_W'(MAX_POINTS)) ? STK_CNT_W'(MAX_POINTS) : k_dec;

    always_comb begin
        sort_we    = 1'b0;
        sort_waddr = j_reg;
        sort_wdata = vin_reg;
        if (state_reg == S_INS_RD && j_reg == '0) begin
            sort_we = 1'b1;
        end else if (state_reg == S_INS_CMP) begin
            sort_we = 1'b1;
            if (pt_less(vin_reg, sort_rd_reg)) begin
                sort_wdata = sort_rd_reg;
            end
        end
        sort_raddr = (state_reg == S_INS_RD) ? j_reg - PTR_W'(1) : idx_reg;
    end

    assign stk_we = (state_reg == S_PUSH) && (k_reg < STK_CNT_W'(STACK_DEPTH));
    assign stk_raddr0 = (state_reg == S_OUT_RD) ? STK_W'(e_reg) : STK_W'(k_reg - STK_CNT_W'(2));
    assign stk_raddr1 = STK_W'(k_reg - STK_CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (s_fire && cnt_reg < CNT_W'(MAX_POINTS)) begin
            store_mem[cnt_reg[PTR_W-1:0]] <= in_pt;
        end
        store_rd_reg <= store_mem[e_reg[PTR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rd_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[k_reg[STK_W-1:0]] <= p_reg;
        end
        stk_rd0_reg <= stk_mem[stk_raddr0];
        stk_rd1_reg <= stk_mem[stk_raddr1];
    end

    assign turn.o = stk_rd0_reg;
    assign turn.a = stk_rd1_reg;
    assign turn.b = p_reg;

    chmc_cross u_cross (
        .aclk (aclk),
        .turn (turn),
        .pop  (pop)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        last_reg <= s_tlast;
                        vin_reg  <= in_pt;
                        if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                            j_reg     <= cnt_reg[PTR_W-1:0];
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= S_INS_RD;
                        end else begin
                            ovf_reg <= 1'b1;
                            if (s_tlast) begin
                                idx_reg   <= '0;
                                k_reg     <= '0;
                                upper_reg <= 1'b0;
                                echo_reg  <= 1'b0;
                                state_reg <= S_HULL_RD;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    if (j_reg == '0) begin
                        priority if (!last_reg) begin
                            state_reg <= S_IDLE;
                        end else if (cnt_reg <= CNT_W'(SMALL_SET)) begin
                            echo_reg  <= 1'b1;
                            e_reg     <= '0;
                            m_reg     <= cnt_reg;
                            state_reg <= S_OUT_RD;
                        end else begin
                            idx_reg   <= '0;
                            k_reg     <= '0;
                            upper_reg <= 1'b0;
                            echo_reg  <= 1'b0;
                            state_reg <= S_HULL_RD;
                        end
                    end else begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (pt_less(vin_reg, sort_rd_reg)) begin
                        j_reg <= j_reg - PTR_W'(1);
                    end else begin
                        j_reg <= '0;
                    end
                    state_reg <= S_INS_RD;
                    if (!pt_less(vin_reg, sort_rd_reg)) begin
                        priority if (!last_reg) begin
                            state_reg <= S_IDLE;
                        end else if (cnt_reg <= CNT_W'(SMALL_SET)) begin
                            echo_reg  <= 1'b1;
                            e_reg     <= '0;
                            m_reg     <= cnt_reg;
                            state_reg <= S_OUT_RD;
                        end else begin
                            idx_reg   <= '0;
                            k_reg     <= '0;
                            upper_reg <= 1'b0;
                            echo_reg  <= 1'b0;
                            state_reg <= S_HULL_RD;
                        end
                    end
                end
                S_HULL_RD: begin
                    state_reg <= S_HULL_GET;
                end
                S_HULL_GET: begin
                    p_reg     <= sort_rd_reg;
                    state_reg <= (k_reg >= limit) ? S_CHK_RD : S_PUSH;
                end
                S_CHK_RD:   state_reg <= S_CHK_FEED;
                S_CHK_FEED: state_reg <= S_CHK_W1;
                S_CHK_W1:   state_reg <= S_CHK_W2;
                S_CHK_W2:   state_reg <= S_CHK_DEC;
                S_CHK_DEC: begin
                    if (pop) begin
                        k_reg     <= k_dec;
                        state_reg <= (k_dec >= limit) ? S_CHK_RD : S_PUSH;
                    end else begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (stk_we) begin
                        k_reg <= k_reg + STK_CNT_W'(1);
                    end
                    state_reg <= S_HULL_RD;
                    if (!upper_reg) begin
                        if (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1)) begin
                            upper_reg <= 1'b1;
                            t_reg     <= k_reg + STK_CNT_W'(2);
                            idx_reg   <= idx_reg - PTR_W'(1);
                        end else begin
                            idx_reg <= idx_reg + PTR_W'(1);
                        end
                    end else if (idx_reg == '0) begin
                        e_reg     <= '0;
                        m_reg     <= (k_reg == '0) ? '0 : CNT_W'(m_full + STK_CNT_W'(1) - STK_CNT_W'(k_reg == STK_CNT_W'(STACK_DEPTH)));
                        state_reg <= S_OUT_RD;
                    end else begin
                        idx_reg <= idx_reg - PTR_W'(1);
                    end
                end
                S_OUT_RD: state_reg <= S_OUT_LD;
                S_OUT_LD: begin
                    out_pt_reg    <= echo_reg ? store_rd_reg : stk_rd0_reg;
                    out_last_reg  <= (e_reg + CNT_W'(1) == m_reg);
                    out_ovf_reg   <= ovf_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end else begin
                            e_reg     <= e_reg + CNT_W'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_pt_reg.y, out_pt_reg.x});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    `include "convex_hull_monotone_chain_defines.svh"

    `CHMC_ASSERT_IMPLY(a_in_out_excl, s_tready, !m_tvalid)
    `CHMC_ASSERT_IMPLY(a_stack_bound, 1'b1, k_reg <= STK_CNT_W'(STACK_DEPTH))
    `CHMC_ASSERT_IMPLY(a_count_bound, 1'b1, cnt_reg <= CNT_W'(MAX_POINTS))
    `CHMC_ASSERT_NEXT(a_run_clear, m_tvalid && m_tready && m_tlast, s_tready && cnt_reg == '0 && !ovf_reg)
endmodule
